@@ rtl/core/bma_pkg.sv @@
// ----------------------------------------------------------------------------
// bma_pkg
// Shared constants for the boxcar moving average: timing of the
// divide-by-window stage.
// ----------------------------------------------------------------------------
package bma_pkg;

  // Register stages added by the divide unit between sum and result.
  // WINDOW is a power of two, so the divide is a plain arithmetic shift.
  localparam int DIV_LATENCY = 0;

endpackage

@@ rtl/core/boxcar_moving_average.sv @@
// ----------------------------------------------------------------------------
// boxcar_moving_average
// Moving average over the last WINDOW samples of a frame, kept as a running
// sum over a sample ring, with a floor divide by WINDOW.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry in_sample (signed) and in_frame_start. A beat with
//   in_frame_start high clears the history before its own sample is added;
//   samples before a frame start count as zero. Every input beat produces
//   exactly one output beat, out_average = floor(window sum / WINDOW).
//   WINDOW must be a power of two; the divide is an arithmetic shift.
//   A beat is taken on a rising edge with valid high and stall low.
// Throughput: one beat per cycle while in_stall is low. The ring entry that
//   leaves the window is prefetched from the ring memory's single read port,
//   so the running-sum update closes in the accepting cycle.
// Order: the edge that takes an input beat updates the running sum; its
//   average is written to the result queue in the next cycle, then read out.
// Reset: rst_n (synchronous, active low) empties the result queue and clears
//   the running sum, fill count and write pointer; the ring needs no clear.
// Stall: results wait in a 3-entry queue. in_stall rises once 3 beats are
//   taken but not yet delivered; at full rate each cycle of out_stall holds
//   back one input beat, in the next cycle.
// ----------------------------------------------------------------------------
module boxcar_moving_average #(
  parameter int WINDOW       = 512,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
  input  logic                           in_frame_start,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_WIDTH-1:0] out_average
);
  import bma_pkg::*;

  localparam int WP_W   = $clog2(WINDOW);
  localparam int FILL_W = $clog2(WINDOW + 1);
  localparam int SUM_W  = SAMPLE_WIDTH + $clog2(WINDOW);
  localparam int PIPE   = 1 + DIV_LATENCY;
  localparam int QD     = PIPE + 2;
  localparam int QP_W   = $clog2(QD);
  localparam int QC_W   = $clog2(QD + 1);

  // Handshakes
  logic in_acc;
  logic out_pop;

  // Window state
  logic [WP_W-1:0]          wp_r;
  logic [WP_W-1:0]          wp_base;
  logic [WP_W-1:0]          wp_nxt;
  logic [WP_W-1:0]          rd_addr;
  logic [FILL_W-1:0]        fill_r;
  logic [FILL_W-1:0]        fill_base;
  logic [FILL_W-1:0]        fill_nxt;
  logic                     win_full;
  logic signed [SUM_W-1:0]  sum_r;
  logic signed [SUM_W-1:0]  sum_base;
  logic signed [SUM_W-1:0]  sum_drop;
  logic signed [SUM_W-1:0]  sum_nxt;
  logic                     sum_vld_r;

  // Ring memory and prefetched oldest sample
  logic signed [SAMPLE_WIDTH-1:0] ring_mem [WINDOW];
  logic signed [SAMPLE_WIDTH-1:0] old_r;

  // Divider output and result queue
  logic                           div_vld;
  logic signed [SAMPLE_WIDTH-1:0] div_avg;
  logic signed [SAMPLE_WIDTH-1:0] q_mem [QD];
  logic [QP_W-1:0]                q_wr_r;
  logic [QP_W-1:0]                q_rd_r;
  logic [QC_W-1:0]                q_cnt_r;
  logic [QC_W-1:0]                occ_r;

  // Credit check: every outstanding beat owns a queue slot
  assign in_stall = (occ_r >= QC_W'(QD));
  assign in_acc   = in_valid && !in_stall;
  assign out_pop  = out_valid && !out_stall;

  // Running-sum update; a frame start clears the history first
  always_comb begin
    wp_base   = in_frame_start ? '0 : wp_r;
    fill_base = in_frame_start ? '0 : fill_r;
    sum_base  = in_frame_start ? '0 : sum_r;
    win_full  = (fill_base == FILL_W'(WINDOW));
    sum_drop  = win_full ? SUM_W'(old_r) : '0;
    sum_nxt   = sum_base - sum_drop + SUM_W'(in_sample);
    fill_nxt  = win_full ? fill_base : fill_base + 1'b1;
    wp_nxt    = (wp_base == WP_W'(WINDOW - 1)) ? '0 : wp_base + 1'b1;
  end

  // Next read slot: the one the following beat will overwrite
  assign rd_addr = in_acc ? wp_nxt : wp_r;

  // Window state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r      <= '0;
      fill_r    <= '0;
      sum_r     <= '0;
      sum_vld_r <= 1'b0;
    end else begin
      sum_vld_r <= in_acc;
      if (in_acc) begin
        wp_r   <= wp_nxt;
        fill_r <= fill_nxt;
        sum_r  <= sum_nxt;
      end
    end
  end

  // Sample ring: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ring_mem[wp_base] <= in_sample;
    end
    old_r <= ring_mem[rd_addr];
  end

  // Divide by WINDOW
  bma_avg_div #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .WINDOW       (WINDOW)
  ) u_div (
    .sum_vld (sum_vld_r),
    .sum     (sum_r),
    .avg_vld (div_vld),
    .avg     (div_avg)
  );

  // Result queue control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wr_r  <= '0;
      q_rd_r  <= '0;
      q_cnt_r <= '0;
      occ_r   <= '0;
    end else begin
      if (div_vld) begin
        q_wr_r <= (q_wr_r == QP_W'(QD - 1)) ? '0 : q_wr_r + 1'b1;
      end
      if (out_pop) begin
        q_rd_r <= (q_rd_r == QP_W'(QD - 1)) ? '0 : q_rd_r + 1'b1;
      end
      q_cnt_r <= q_cnt_r + QC_W'(div_vld) - QC_W'(out_pop);
      occ_r   <= occ_r + QC_W'(in_acc) - QC_W'(out_pop);
    end
  end

  // Result queue storage
  always_ff @(posedge clk) begin
    if (div_vld) begin
      q_mem[q_wr_r] <= div_avg;
    end
  end

  assign out_valid   = (q_cnt_r != '0);
  assign out_average = q_mem[q_rd_r];

  // Checks
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= QC_W'(QD))
    else $error("outstanding beat count exceeds result queue depth");

  a_q_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    div_vld |-> (q_cnt_r < QC_W'(QD)) || out_pop)
    else $error("result queue written while full");

  a_q_within_occ: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r <= occ_r)
    else $error("queued results exceed outstanding beats");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(WINDOW))
    else $error("fill count beyond window");

  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_frame_start |=> (fill_r == FILL_W'(1)) && (wp_r == WP_W'(1)))
    else $error("frame start did not restart the window");

endmodule

@@ rtl/core/bma_avg_div.sv @@
// ----------------------------------------------------------------------------
// bma_avg_div
// Floor division of the signed window sum by WINDOW. WINDOW is a power of
// two, so the divide is an arithmetic shift with no added stages.
// ----------------------------------------------------------------------------
module bma_avg_div #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int WINDOW       = 512
) (
  input  logic                                               sum_vld,
  input  logic signed [SAMPLE_WIDTH+$clog2(WINDOW)-1:0]      sum,
  output logic                                               avg_vld,
  output logic signed [SAMPLE_WIDTH-1:0]                     avg
);

  localparam int L = $clog2(WINDOW);

  // floor(sum / 2^L): arithmetic shift, result always fits the sample range
  assign avg     = SAMPLE_WIDTH'(sum >>> L);
  assign avg_vld = sum_vld;

endmodule

@@ test/boxcar_moving_average_checker.sv @@
// ----------------------------------------------------------------------------
// boxcar_moving_average_checker
// Watches both channels of the boxcar moving average. A running-sum model
// predicts the average for every input beat taken. Each output beat taken is
// compared in order against those predictions. It reports the number of
// mismatches and the number of averages still owed.
// ----------------------------------------------------------------------------
module boxcar_moving_average_checker #(
  parameter int WINDOW       = 512,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
  input  logic                           in_frame_start,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] out_average,
  output int                             error_count,
  output int                             pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

  // Model state: sample ring, next slot, valid depth, running sum
  sample_t history [WINDOW];
  int      slot;
  int      filled;
  longint  window_total;

  // Averages owed by the block, oldest first
  sample_t average_q [$];
  int      results_seen;

  initial begin
    error_count  = 0;
    pending      = 0;
    results_seen = 0;
  end

  task automatic report_mismatch(input string what);
    $display("%0t ns: average beat %0d: %s", $time, results_seen, what);
    error_count++;
  endtask

  // Take one sample into the window and return the floored average
  function automatic sample_t advance_average(input sample_t s, input logic fs);
    longint q;
    if (fs) begin
      filled       = 0;
      window_total = 0;
      slot         = 0;
    end
    // once full, the oldest sample drops out of the window
    if (filled >= WINDOW) window_total -= history[slot];
    else filled++;
    window_total += s;
    history[slot] = s;
    slot = (slot + 1) % WINDOW;
    // floor division, rounding toward minus infinity
    if (window_total >= 0) q = window_total / WINDOW;
    else q = -((-window_total + WINDOW - 1) / WINDOW);
    return sample_t'(q);
  endfunction

  always @(posedge clk) begin : watch
    sample_t expected;
    if (!rst_n) begin
      average_q.delete();
      filled       = 0;
      window_total = 0;
      slot         = 0;
    end else begin
      // output beat against the oldest prediction
      if (out_valid && !out_stall) begin
        if (average_q.size() == 0) begin
          report_mismatch($sformatf("unexpected average %0d", out_average));
        end else begin
          expected = average_q.pop_front();
          if (out_average !== expected)
            report_mismatch($sformatf("average %0d, want %0d", out_average, expected));
        end
        results_seen++;
      end
      // input beat: predict its average
      if (in_valid && !in_stall)
        average_q.push_back(advance_average(in_sample, in_frame_start));
    end
    pending = average_q.size();
  end

endmodule

@@ test/boxcar_moving_average_tb.sv @@
// ----------------------------------------------------------------------------
// boxcar_moving_average_tb
// Drives sample beats into the boxcar moving average and gives the verdict.
// A short directed run covers sample extremes, the first frame without a
// start flag, back-to-back frame starts and floor rounding. Random frames
// follow: two long ones that fill the window at full-scale values, then many
// short ones with random content and stray frame starts. Both sides idle at
// random, with one long stretch at full rate. Checking is done by the
// checker instance.
// ----------------------------------------------------------------------------
module boxcar_moving_average_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WINDOW       = 512;
  localparam int SAMPLE_WIDTH = 16;
  localparam int BEAT_TARGET  = 1850;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 12 + bma_pkg::DIV_LATENCY;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef enum int {FILL_RANDOM, FILL_MAX, FILL_MIN, FILL_EXTREME, FILL_TINY} fill_mode_t;

  localparam sample_t S_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam sample_t S_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  logic    clk = 1'b0;
  logic    rst_n = 1'b0;
  logic    in_valid = 1'b0;
  logic    in_stall;
  sample_t in_sample = '0;
  logic    in_frame_start = 1'b0;
  logic    out_valid;
  logic    out_stall = 1'b0;
  sample_t out_average;

  int mismatches;
  int awaiting;
  int beats_sent = 0;
  int cycle_count = 0;
  bit calm = 1'b0;

  boxcar_moving_average #(
    .WINDOW       (WINDOW),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample      (in_sample),
    .in_frame_start (in_frame_start),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_average    (out_average)
  );

  boxcar_moving_average_checker #(
    .WINDOW       (WINDOW),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample      (in_sample),
    .in_frame_start (in_frame_start),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_average    (out_average),
    .error_count    (mismatches),
    .pending        (awaiting)
  );

  always #10 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[boxcar_moving_average] ERROR");
      $finish;
    end
  end

  // Receiver stalls at random, except during the full-rate stretch
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= !calm && ($urandom_range(0, 99) < 32);
  end

  // One beat: optional idle cycles, then hold until taken
  task automatic drive_beat(input sample_t s, input logic fs);
    calm = (beats_sent >= 700) && (beats_sent < 1100);
    while (!calm && ($urandom_range(0, 99) < 32)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_sample      <= s;
    in_frame_start <= fs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
  endtask

  function automatic sample_t pick_sample(input fill_mode_t mode);
    case (mode)
      FILL_MAX:     return S_MAX;
      FILL_MIN:     return S_MIN;
      FILL_EXTREME: return $urandom_range(0, 1) ? S_MAX : S_MIN;
      FILL_TINY:    return sample_t'(int'($urandom_range(0, 6)) - 3);
      default:      return sample_t'($urandom_range(0, (1 << SAMPLE_WIDTH) - 1));
    endcase
  endfunction

  initial begin : stimulus
    int         frame_no;
    int         frame_len;
    fill_mode_t mode;
    sample_t    s;
    logic       fs;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // first frame runs without a start flag after reset
    drive_beat(S_MAX, 1'b0);
    drive_beat(S_MAX, 1'b0);
    drive_beat(S_MIN, 1'b0);
    drive_beat(sample_t'(-1), 1'b0);
    drive_beat(sample_t'(0), 1'b0);
    drive_beat(sample_t'(1), 1'b0);
    // frame starts at the extremes, back to back
    drive_beat(S_MIN, 1'b1);
    drive_beat(S_MIN, 1'b0);
    drive_beat(S_MIN, 1'b0);
    drive_beat(S_MAX, 1'b1);
    drive_beat(S_MAX, 1'b1);
    drive_beat(sample_t'(-1), 1'b1);
    drive_beat(sample_t'(1), 1'b1);
    // floor rounding around the window boundary
    drive_beat(sample_t'(511), 1'b1);
    drive_beat(sample_t'(1), 1'b0);
    drive_beat(sample_t'(-512), 1'b1);
    drive_beat(sample_t'(-1), 1'b0);
    drive_beat(sample_t'(-513), 1'b1);
    // alternating bit patterns
    drive_beat(16'sh5555, 1'b0);
    drive_beat(16'shAAAA, 1'b0);
    drive_beat(sample_t'(0), 1'b1);

    // Random frames. The first two overfill the window at full scale,
    // then continue with random samples so the drop-out path sees them.
    frame_no = 0;
    while (beats_sent < BEAT_TARGET) begin
      if (frame_no < 2) begin
        frame_len = $urandom_range(WINDOW + 1, WINDOW + 90);
        mode      = FILL_RANDOM;
      end else begin
        frame_len = $urandom_range(1, 48);
        mode      = fill_mode_t'($urandom_range(0, 4));
      end
      for (int k = 0; k < frame_len; k++) begin
        if (frame_no < 2 && k < WINDOW) s = (frame_no == 0) ? S_MAX : S_MIN;
        else s = pick_sample(mode);
        // stray frame starts break a few short frames
        fs = (k == 0) || (frame_no >= 2 && $urandom_range(0, 49) == 0);
        drive_beat(s, fs);
      end
      frame_no++;
    end
    in_valid <= 1'b0;
    // let the checker take in the last beat before counting what is owed
    @(posedge clk);

    // drain: every average back, then a few quiet cycles
    while (awaiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && awaiting == 0) $display("[boxcar_moving_average] OK");
    else $display("[boxcar_moving_average] ERROR");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/bma_pkg.sv
rtl/core/bma_avg_div.sv
rtl/core/boxcar_moving_average.sv
test/boxcar_moving_average_checker.sv
test/boxcar_moving_average_tb.sv
